FILE: rtl/bb3_pkg.sv
package bb3_pkg;

  // Frame limits and field widths
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WID_W        = 11;
  localparam int HGT_W        = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Sum of up to nine 8-bit samples, neighbor count 1..9
  localparam int SUM_W = 12;
  localparam int CNT_W = 4;
  localparam int QUO_W = 8;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_pair_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } rgb_sum_t;

  // Window control from the sequencer
  typedef struct packed {
    logic       shift;
    logic       sum;
    logic [1:0] sel;
    logic       row_ge1;
    logic       row_ge2;
    logic       col_ge1;
    logic       col_ge2;
  } win_ctrl_t;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDMEM,
    ST_SUM,
    ST_START,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Result slots of one item; bit index into the pending mask.
  // sel[1] = 1 -> output row is r, else r-1; sel[0] = 1 -> column c, else c-1
  localparam logic [1:0] RES_UP_LEFT = 2'd0;
  localparam logic [1:0] RES_UP      = 2'd1;
  localparam logic [1:0] RES_LEFT    = 2'd2;
  localparam logic [1:0] RES_HERE    = 2'd3;

endpackage

FILE: rtl/box_blur_3x3_edge_average_top.sv
// 3x3 box blur of an RGB pixel stream, averaging only neighbors inside the image.
// Input: s_axis carries one pixel per item in raster order. Output: m_axis carries
// blurred pixels with their row and column; tlast marks the final result that an
// input item caused. One input causes 0 to 4 results (bottom-right corner: 4).
// Config: cfg_index_i 0 = image width (1..1024), 1 = image height (1..4096);
// zero acts as 1, larger values as the maximum. Write only while the block is idle.
// Sequence: an item takes a memory read, then per result a window sum, a divider
// start, the 8-step rounded-mean divider (three channels at once) and the output
// load. Input is accepted only when the previous item is fully done.
// Results go through one output register: the next input is accepted while a
// result still waits there; a stalled receiver holds the sequencer at the load step.
// Reset: counters restart at row 0, column 0, window cleared, size 640x480.
// The line stores are not cleared; within a frame of fixed size no unwritten
// entry reaches a sum.
module box_blur_3x3_edge_average_top import bb3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_row[35:24], out_col[45:36]
  output logic [47:0]           m_axis_tdata,
  output logic                  m_axis_tlast,   // last_of_run
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e           state_q, state_d;
  logic [WID_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] r_q;
  logic [COL_W-1:0] c_q;
  pix_t             pix_q;
  logic [3:0]       pend_q, pend_d;

  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [COL_W-1:0] wm1, c_cur;
  logic [ROW_W-1:0] hm1, r_cur;
  logic             c_last, r_last, in_acc;
  logic [1:0]       sel;
  logic [3:0]       pend_rest;

  line_pair_t       rd_data;
  line_pair_t       wr_data;
  win_ctrl_t        win_ctrl;
  rgb_sum_t         win_sum;
  logic [CNT_W-1:0] win_cnt;
  logic             div_start, div_done;
  pix_t             div_quot;

  logic             out_valid_q;
  logic             out_load;
  pix_t             out_pix_q;
  logic [ROW_W-1:0] out_row_q;
  logic [COL_W-1:0] out_col_q;
  logic             out_last_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WID_W'(RESET_WIDTH);
      height_q <= HGT_W'(RESET_HEIGHT);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i[WID_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective size and position of the incoming pixel
  always_comb begin
    if (width_q == '0) begin
      w_eff = WID_W'(1);
    end else if (width_q > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = HGT_W'(1);
    end else if (height_q > HGT_W'(MAX_HEIGHT)) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    wm1    = COL_W'(w_eff - WID_W'(1));
    hm1    = ROW_W'(h_eff - HGT_W'(1));
    // counters left over from a larger frame restart at zero
    c_cur  = (WID_W'(col_q) >= w_eff) ? '0 : col_q;
    r_cur  = (HGT_W'(row_q) >= h_eff) ? '0 : row_q;
    c_last = (c_cur == wm1);
    r_last = (r_cur == hm1);
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Lowest pending result goes first
  always_comb begin
    if (pend_q[RES_UP_LEFT]) begin
      sel = RES_UP_LEFT;
    end else if (pend_q[RES_UP]) begin
      sel = RES_UP;
    end else if (pend_q[RES_LEFT]) begin
      sel = RES_LEFT;
    end else begin
      sel = RES_HERE;
    end
    pend_rest      = pend_q;
    pend_rest[sel] = 1'b0;
  end

  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    pend_d    = pend_q;
    row_d     = row_q;
    col_d     = col_q;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pend_d[RES_UP_LEFT] = (r_cur != '0) && (c_cur != '0);
          pend_d[RES_UP]      = (r_cur != '0) && c_last;
          pend_d[RES_LEFT]    = r_last && (c_cur != '0);
          pend_d[RES_HERE]    = r_last && c_last;
          if (c_last) begin
            col_d = '0;
            row_d = r_last ? '0 : r_cur + ROW_W'(1);
          end else begin
            col_d = c_cur + COL_W'(1);
            row_d = r_cur;
          end
          state_d = ST_RDMEM;
        end
      end
      ST_RDMEM: begin
        state_d = (pend_q != '0) ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        state_d = ST_START;
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          pend_d  = pend_rest;
          state_d = (pend_rest != '0) ? ST_SUM : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      r_q   <= r_cur;
      c_q   <= c_cur;
      pix_q <= '{red:   s_axis_tdata[7:0],
                 green: s_axis_tdata[15:8],
                 blue:  s_axis_tdata[23:16]};
    end
  end

  // Line stores: read at accept, write back the shifted pair in the following cycle
  assign wr_data.older = rd_data.newer;
  assign wr_data.newer = pix_q;

  bb3_line_mem u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (c_cur),
    .rd_data_o (rd_data),
    .wr_en_i   (state_q == ST_RDMEM),
    .wr_addr_i (c_q),
    .wr_data_i (wr_data)
  );

  assign win_ctrl.shift   = (state_q == ST_RDMEM);
  assign win_ctrl.sum     = (state_q == ST_SUM);
  assign win_ctrl.sel     = sel;
  assign win_ctrl.row_ge1 = (r_q >= ROW_W'(1));
  assign win_ctrl.row_ge2 = (r_q >= ROW_W'(2));
  assign win_ctrl.col_ge1 = (c_q >= COL_W'(1));
  assign win_ctrl.col_ge2 = (c_q >= COL_W'(2));

  bb3_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (win_ctrl),
    .above2_i (rd_data.older),
    .above1_i (rd_data.newer),
    .pix_i    (pix_q),
    .sum_o    (win_sum),
    .cnt_o    (win_cnt)
  );

  bb3_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (win_sum),
    .cnt_i   (win_cnt),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q  <= div_quot;
      out_row_q  <= sel[1] ? r_q : r_q - ROW_W'(1);
      out_col_q  <= sel[0] ? c_q : c_q - COL_W'(1);
      out_last_q <= (pend_rest == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_col_q, out_row_q,
                          out_pix_q.blue, out_pix_q.green, out_pix_q.red};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
  // Line-store data is consumed only right after an accepted pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDMEM) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("read stage entered without an accepted pixel");

  // A new result shows up only from the emit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_EMIT))
    else $error("output valid rose outside the emit step");

  // Emitting needs a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (pend_q != '0))
    else $error("emit step with nothing pending");

  // The output pixel itself is always in the window, so the divisor is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (win_cnt != '0))
    else $error("divider started with zero neighbor count");
`endif

endmodule

FILE: rtl/bb3_line_mem.sv
module bb3_line_mem import bb3_pkg::*; (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] rd_addr_i,
  output line_pair_t       rd_data_o,
  input  logic             wr_en_i,
  input  logic [COL_W-1:0] wr_addr_i,
  input  line_pair_t       wr_data_i
);

  // Both line stores share one entry per column: {two rows up, one row up}
  line_pair_t mem_q [MAX_WIDTH];
  line_pair_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: rtl/bb3_window.sv
module bb3_window import bb3_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  win_ctrl_t        ctrl_i,
  input  pix_t             above2_i,
  input  pix_t             above1_i,
  input  pix_t             pix_i,
  output rgb_sum_t         sum_o,
  output logic [CNT_W-1:0] cnt_o
);

  pix_t             win_q [3][3];
  logic [2:0]       row_ok;
  logic [2:0]       col_ok;
  rgb_sum_t         sum_d, sum_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        for (int m = 0; m < 3; m++) begin
          win_q[k][m] <= '0;
        end
      end
    end else if (ctrl_i.shift) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= win_q[k][1];
        win_q[k][1] <= win_q[k][2];
      end
      win_q[0][2] <= above2_i;
      win_q[1][2] <= above1_i;
      win_q[2][2] <= pix_i;
    end
  end

  // Rows r-2..r and columns c-2..c; keep only those in the image and next to the center
  always_comb begin
    row_ok[0] = ctrl_i.row_ge2 & ~ctrl_i.sel[1];
    row_ok[1] = ctrl_i.row_ge1;
    row_ok[2] = 1'b1;
    col_ok[0] = ctrl_i.col_ge2 & ~ctrl_i.sel[0];
    col_ok[1] = ctrl_i.col_ge1;
    col_ok[2] = 1'b1;
  end

  always_comb begin
    sum_d = '0;
    cnt_d = '0;
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        if (row_ok[k] && col_ok[m]) begin
          sum_d.red   = sum_d.red   + SUM_W'(win_q[k][m].red);
          sum_d.green = sum_d.green + SUM_W'(win_q[k][m].green);
          sum_d.blue  = sum_d.blue  + SUM_W'(win_q[k][m].blue);
          cnt_d       = cnt_d + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  assign sum_o = sum_q;
  assign cnt_o = cnt_q;

endmodule

FILE: rtl/bb3_div.sv
module bb3_div import bb3_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  rgb_sum_t         sum_i,
  input  logic [CNT_W-1:0] cnt_i,
  output pix_t             quot_o,
  output logic             done_o
);

  // Rounded mean (2*sum+cnt)/(2*cnt), one quotient bit per cycle, three channels.
  // The quotient fits QUO_W bits, so the upper numerator bits start below the divisor.
  localparam int NUM_W  = SUM_W + 1;
  localparam int DEN_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(QUO_W);

  logic [NUM_W-1:0]  num     [3];
  logic [SUM_W-1:0]  sum_ch  [3];
  logic [DEN_W-1:0]  rem_q   [3];
  logic [DEN_W-1:0]  rem_d   [3];
  logic [QUO_W-1:0]  quo_q   [3];
  logic [QUO_W-1:0]  quo_d   [3];
  logic [DEN_W:0]    trial   [3];
  logic [DEN_W-1:0]  den_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;

  assign sum_ch[0] = sum_i.red;
  assign sum_ch[1] = sum_i.green;
  assign sum_ch[2] = sum_i.blue;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      num[ch]   = {sum_ch[ch], 1'b0} + NUM_W'(cnt_i);
      trial[ch] = {rem_q[ch], quo_q[ch][QUO_W-1]};
      if (trial[ch] >= {1'b0, den_q}) begin
        rem_d[ch] = DEN_W'(trial[ch] - {1'b0, den_q});
        quo_d[ch] = {quo_q[ch][QUO_W-2:0], 1'b1};
      end else begin
        rem_d[ch] = trial[ch][DEN_W-1:0];
        quo_d[ch] = {quo_q[ch][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= {cnt_i, 1'b0};
      for (int ch = 0; ch < 3; ch++) begin
        rem_q[ch] <= num[ch][NUM_W-1:QUO_W];
        quo_q[ch] <= num[ch][QUO_W-1:0];
      end
    end else if (busy_q) begin
      for (int ch = 0; ch < 3; ch++) begin
        rem_q[ch] <= rem_d[ch];
        quo_q[ch] <= quo_d[ch];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(QUO_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign quot_o = '{red: quo_q[0], green: quo_q[1], blue: quo_q[2]};
  assign done_o = done_q;

endmodule

FILE: tb/sv/tb_box_blur_3x3_edge_average_top.sv
module tb_box_blur_3x3_edge_average_top;
  import bb3_pkg::*;

  localparam int RANDOM_ITEMS      = 260;
  localparam int SETTLE_CYCLES     = 80;     // worst item (four results), plus slack
  localparam int SINK_HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS       = 10;
  localparam int TIMEOUT_UNITS     = 10_000_000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_e;

  // One blurred pixel as it leaves the block
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } blur_out_t;

  // Predicts the blurred pixels of every accepted input item and matches them
  // against what comes out, in order.
  class blur_scoreboard;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    pix_t        older_line [MAX_WIDTH];
    pix_t        newer_line [MAX_WIDTH];
    pix_t        tap [3][3];   // rows r-2..r, columns c-2..c
    int          row_pos;
    int          col_pos;
    blur_out_t   pending [$];
    int          mismatches;
    int          pixels_seen;
    int          results_seen;
    int          reg_writes;

    function new();
      width_reg    = 11'(RESET_WIDTH);
      height_reg   = 13'(RESET_HEIGHT);
      row_pos      = 0;
      col_pos      = 0;
      mismatches   = 0;
      pixels_seen  = 0;
      results_seen = 0;
      reg_writes   = 0;
      foreach (older_line[i]) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      foreach (tap[k, m]) tap[k][m] = '0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_WIDTH) begin
        width_reg = val[10:0];
      end else begin
        height_reg = val[12:0];
      end
      reg_writes++;
    endfunction

    function bit at_frame_start();
      return row_pos == 0 && col_pos == 0;
    endfunction

    // Mean of the in-image neighbors of (orow, ocol), rounded half up
    function blur_out_t blur_at(int orow, int ocol, int r, int c, int w, int h);
      int sum_r, sum_g, sum_b, cnt, ir, ic;
      blur_out_t o;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      cnt   = 0;
      for (int k = 0; k < 3; k++) begin
        for (int m = 0; m < 3; m++) begin
          ir = r - 2 + k;
          ic = c - 2 + m;
          if (ir < 0 || ir >= h || ic < 0 || ic >= w) continue;
          if (ir - orow > 1 || orow - ir > 1 || ic - ocol > 1 || ocol - ic > 1) continue;
          sum_r += tap[k][m].red;
          sum_g += tap[k][m].green;
          sum_b += tap[k][m].blue;
          cnt++;
        end
      end
      o.red   = 8'((2 * sum_r + cnt) / (2 * cnt));
      o.green = 8'((2 * sum_g + cnt) / (2 * cnt));
      o.blue  = 8'((2 * sum_b + cnt) / (2 * cnt));
      o.row   = 12'(orow);
      o.col   = 10'(ocol);
      o.last  = 1'b0;
      return o;
    endfunction

    function void note_pixel(pix_t px);
      int        w, h, r, c;
      pix_t      up2, up1;
      blur_out_t batch [$];
      w = width_reg;
      h = height_reg;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      // size shrunk under the counters: restart them
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = col_pos;

      up2 = older_line[c];
      up1 = newer_line[c];
      older_line[c] = up1;
      newer_line[c] = px;
      for (int k = 0; k < 3; k++) begin
        tap[k][0] = tap[k][1];
        tap[k][1] = tap[k][2];
      end
      tap[0][2] = up2;
      tap[1][2] = up1;
      tap[2][2] = px;

      if (r >= 1 && c >= 1) batch.push_back(blur_at(r - 1, c - 1, r, c, w, h));
      if (r >= 1 && c == w - 1) batch.push_back(blur_at(r - 1, c, r, c, w, h));
      if (r == h - 1 && c >= 1) batch.push_back(blur_at(r, c - 1, r, c, w, h));
      if (r == h - 1 && c == w - 1) batch.push_back(blur_at(r, c, r, c, w, h));
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending.push_back(batch[i]);

      if (c >= w - 1) begin
        col_pos = 0;
        row_pos = (r >= h - 1) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
      pixels_seen++;
    endfunction

    function void check_result(logic [47:0] data, logic last);
      blur_out_t got, want;
      got.red   = data[7:0];
      got.green = data[15:8];
      got.blue  = data[23:16];
      got.row   = data[35:24];
      got.col   = data[45:36];
      got.last  = last;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d with none outstanding: rgb %0d/%0d/%0d at (%0d,%0d) last %0b",
                   results_seen, got.red, got.green, got.blue, got.row, got.col, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.row !== want.row || got.col !== want.col || got.last !== want.last ||
          data[47:46] !== 2'b00) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result %0d: expected rgb %0d/%0d/%0d at (%0d,%0d) last %0b",
                   results_seen, want.red, want.green, want.blue, want.row, want.col,
                   want.last);
          $display("  actual rgb %0d/%0d/%0d at (%0d,%0d) last %0b pad %b",
                   got.red, got.green, got.blue, got.row, got.col, got.last, data[47:46]);
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [47:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic                  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  blur_scoreboard blur_sb = new();

  int src_idle_pct;
  int sink_stall_pct;
  int holds_asked;
  int holds_served;
  int hold_left;
  int frame_settings;

  box_blur_3x3_edge_average_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Result sink: random stalls, plus a long hold-off whenever one is requested
  initial begin
    hold_left    = 0;
    holds_served = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_served != holds_asked) begin
        holds_served++;
        hold_left = SINK_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      blur_sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("box_blur_3x3_edge_average_top verification failed");
    $finish;
  end

  function automatic pix_t rand_pixel();
    pix_t px;
    px.red   = 8'($urandom_range(255));
    px.green = 8'($urandom_range(255));
    px.blue  = 8'($urandom_range(255));
    return px;
  endfunction

  function automatic void set_idling(idle_mode_e mode);
    src_idle_pct   = (mode == IDLE_SRC) ? 47 : (mode == IDLE_BOTH) ? 24 : 0;
    sink_stall_pct = (mode == IDLE_SINK) ? 47 : (mode == IDLE_BOTH) ? 24 : 0;
  endfunction

  // Offer one pixel, with a random gap first; valid stays up after the
  // handshake so back-to-back items need no extra assignment.
  task automatic push_pixel(pix_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {px.blue, px.green, px.red};
    do @(posedge clk_i); while (!s_axis_tready);
    blur_sb.note_pixel(px);
  endtask

  task automatic stream_pixels(int count);
    for (int i = 0; i < count; i++) push_pixel(rand_pixel());
  endtask

  // Drain: every expected result in, then enough cycles for an item that
  // produces nothing to finish inside the block.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (blur_sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One write, then valid drops so back-to-back writes keep valid clean
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    blur_sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Width only uses its low 11 bits; the spare bits get junk on purpose
  task automatic set_frame(int w, int h);
    settle();
    write_reg(CFG_WIDTH, {2'($urandom_range(3)), 11'(w)});
    write_reg(CFG_HEIGHT, 13'(h));
    frame_settings++;
  endtask

  initial begin
    int w, h, we, he, random_start;
    pix_t px;

    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_WIDTH;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    holds_asked    = 0;
    frame_settings = 0;
    set_idling(IDLE_NONE);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset size 640x480: a stretch of row 0 gives no result yet
    stream_pixels(20);
    // Height cut to 1 mid-row: row 0 is now the last row and the column keeps
    // counting from 20, so each pixel blurs its left neighbor. The sink holds
    // off for a long stretch to back the block up.
    settle();
    write_reg(CFG_HEIGHT, 13'd1);
    holds_asked++;
    stream_pixels(30);

    // Size shrunk mid-frame: column counter (now 50) must restart
    set_idling(IDLE_SRC);
    set_frame(6, 5);
    stream_pixels(2 * 6 + 4);
    // column counter at 4, width drops to 3 -> column restarts on row 2
    settle();
    write_reg(CFG_WIDTH, 13'd3);
    stream_pixels(3 * 3);
    // partial frame, then height drops below the row counter
    stream_pixels(4);
    settle();
    write_reg(CFG_HEIGHT, 13'd1);
    stream_pixels(5);
    while (!blur_sb.at_frame_start()) push_pixel(rand_pixel());

    // Directed: zero sizes act as 1, channel extremes, half-up rounding
    set_idling(IDLE_SINK);
    set_frame(0, 0);
    push_pixel('0);
    push_pixel('1);
    set_frame(2, 1);
    px = '0;
    push_pixel(px);
    px.red   = 8'd1;
    px.green = 8'd255;
    px.blue  = 8'd1;
    push_pixel(px);
    set_frame(3, 3);
    for (int i = 0; i < 9; i++) begin
      px.red   = (i % 2 == 0) ? 8'd255 : 8'd0;
      px.green = ~px.red;
      px.blue  = 8'(i * 31);
      push_pixel(px);
    end
    set_frame(1, 3);
    push_pixel('1);
    push_pixel('0);
    push_pixel(24'h80FF01);

    // Oversized values clamp to the maximum instead of wrapping small
    set_idling(IDLE_BOTH);
    settle();
    write_reg(CFG_WIDTH, 13'h1FFF);
    write_reg(CFG_HEIGHT, 13'd1);
    stream_pixels(24);
    set_idling(IDLE_NONE);
    settle();
    write_reg(CFG_WIDTH, 13'd3);
    write_reg(CFG_HEIGHT, 13'h1FFF);
    stream_pixels(15);
    // height cut under the row counter, so the random frames start at row 0
    settle();
    write_reg(CFG_HEIGHT, 13'd1);
    while (!blur_sb.at_frame_start()) push_pixel(rand_pixel());

    // Random frames, mostly small; some are cut short by a mid-frame shrink
    random_start = blur_sb.pixels_seen;
    while (blur_sb.pixels_seen < random_start + RANDOM_ITEMS) begin
      w  = ($urandom_range(7) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 0);
      h  = $urandom_range(6, 0);
      we = (w == 0) ? 1 : w;
      he = (h == 0) ? 1 : h;
      set_idling(idle_mode_e'(frame_settings % 4));
      set_frame(w, h);
      if ($urandom_range(4) == 0 && we * he > 1) begin
        stream_pixels($urandom_range(we * he - 1, 1));
        settle();
        write_reg(CFG_WIDTH, 13'($urandom_range(we, 1)));
        write_reg(CFG_HEIGHT, 13'($urandom_range(he, 1)));
        do push_pixel(rand_pixel()); while (!blur_sb.at_frame_start());
      end else begin
        stream_pixels(we * he);
      end
    end

    settle();
    $display("covered %0d pixels over %0d frame sizes with %0d register writes",
             blur_sb.pixels_seen, frame_settings, blur_sb.reg_writes);
    $display("checked %0d blurred pixels, %0d mismatches, %0d long sink hold-offs",
             blur_sb.results_seen, blur_sb.mismatches, holds_served);
    if (blur_sb.mismatches == 0 && blur_sb.pending.size() == 0) begin
      $display("box_blur_3x3_edge_average_top verification clean");
    end else begin
      $display("box_blur_3x3_edge_average_top verification failed");
    end
    $finish;
  end

endmodule
